// ----- design/spint_pkg.sv -----
// shared types, codes and constants of the setpoint profile interpolator
`default_nettype none

package spint_pkg;

   // table geometry and field widths
   localparam int POINTS_DEFAULT = 16;
   localparam int SLOT_W         = 4;
   localparam int DATA_W         = 16;
   localparam int KIND_W         = 2;
   localparam int PHASE_W        = 2;
   localparam int INTERVAL_W     = 8;

   // arithmetic widths of the interpolation
   localparam int SPAN_W = DATA_W + 1;
   localparam int PROD_W = 2 * SPAN_W;
   localparam int DIV_W  = PROD_W;
   localparam int REM_W  = DATA_W + 2;
   localparam int CNT_W  = $clog2(DIV_W);

   localparam logic [DATA_W-1:0]     TIME_LIMIT     = 16'd1000;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd1;

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_START = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EVAL  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_STOP  = 2'd3;

   // run phase codes
   localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_RUN  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_DONE = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CUR_CHK,
      ST_PREV_CHK,
      ST_MUL,
      ST_DIV_INIT,
      ST_DIV,
      ST_FIN,
      ST_PH_RD,
      ST_PH_CHK
   } ctrl_state_type;

   typedef struct packed {
      logic load_item;
      logic do_write;
      logic do_start;
      logic do_stop;
      logic rd_cur;
      logic rd_prev;
      logic apply;
      logic arm;
      logic prev_load;
      logic mul;
      logic div_init;
      logic div_step;
      logic finish;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              running;
      logic              slot_done;
      logic              reached;
      logic              interval_ok;
      logic              index_nonzero;
      logic              span_pos;
      logic              div_last;
      logic              rsp_free;
   } status_type;

endpackage

`default_nettype wire

// ----- design/spint_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none

module spint_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/spint_ctrl.sv -----
// sequencing state machine of the setpoint profile interpolator
`default_nettype none

module spint_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  spint_pkg::status_type  status,
   output spint_pkg::cmd_type     cmd
);

   spint_pkg::ctrl_state_type state_ff;
   spint_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spint_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spint_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = spint_pkg::ST_EXEC;
            end
         end
         spint_pkg::ST_EXEC: begin
            if (status.kind == spint_pkg::KIND_EVAL && status.running) begin
               state_in = spint_pkg::ST_CUR_CHK;
            end else begin
               state_in = spint_pkg::ST_PH_RD;
            end
         end
         spint_pkg::ST_CUR_CHK: begin
            if (status.slot_done) begin
               state_in = spint_pkg::ST_PH_CHK;
            end else if (status.reached) begin
               state_in = spint_pkg::ST_PH_RD;
            end else if (status.interval_ok && status.index_nonzero) begin
               state_in = spint_pkg::ST_PREV_CHK;
            end else begin
               state_in = spint_pkg::ST_PH_CHK;
            end
         end
         spint_pkg::ST_PREV_CHK: begin
            if (status.span_pos) begin
               state_in = spint_pkg::ST_MUL;
            end else begin
               state_in = spint_pkg::ST_PH_RD;
            end
         end
         spint_pkg::ST_MUL:      state_in = spint_pkg::ST_DIV_INIT;
         spint_pkg::ST_DIV_INIT: state_in = spint_pkg::ST_DIV;
         spint_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = spint_pkg::ST_FIN;
            end
         end
         spint_pkg::ST_FIN:   state_in = spint_pkg::ST_PH_RD;
         spint_pkg::ST_PH_RD: state_in = spint_pkg::ST_PH_CHK;
         spint_pkg::ST_PH_CHK: begin
            if (status.rsp_free) begin
               state_in = spint_pkg::ST_IDLE;
            end
         end
         default: state_in = spint_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != spint_pkg::ST_IDLE);
      case (state_ff)
         spint_pkg::ST_IDLE: cmd.load_item = req_valid;
         spint_pkg::ST_EXEC: begin
            cmd.do_write = (status.kind == spint_pkg::KIND_WRITE);
            cmd.do_start = (status.kind == spint_pkg::KIND_START);
            cmd.do_stop  = (status.kind == spint_pkg::KIND_STOP);
            cmd.rd_cur   = (status.kind == spint_pkg::KIND_EVAL) && status.running;
         end
         spint_pkg::ST_CUR_CHK: begin
            cmd.apply = !status.slot_done && status.reached;
            if (!status.slot_done && !status.reached && status.interval_ok &&
                status.index_nonzero) begin
               cmd.arm     = 1'b1;
               cmd.rd_prev = 1'b1;
            end
         end
         spint_pkg::ST_PREV_CHK: cmd.prev_load = 1'b1;
         spint_pkg::ST_MUL:      cmd.mul       = 1'b1;
         spint_pkg::ST_DIV_INIT: cmd.div_init  = 1'b1;
         spint_pkg::ST_DIV:      cmd.div_step  = 1'b1;
         spint_pkg::ST_FIN:      cmd.finish    = 1'b1;
         spint_pkg::ST_PH_RD:    cmd.rd_cur    = 1'b1;
         spint_pkg::ST_PH_CHK:   cmd.load_rsp  = status.rsp_free;
         default: cmd = '0;
      endcase
   end

   // the divider runs its full count before the result is formed
   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == spint_pkg::ST_DIV && !status.div_last |=> state_ff == spint_pkg::ST_DIV)
      else $error("divider left before its last step");

   // a point is applied only during a running evaluation
   a_no_apply_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> state_ff == spint_pkg::ST_CUR_CHK && status.running)
      else $error("point applied outside a running evaluation");

   // a result is loaded only into a free output register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> status.rsp_free)
      else $error("result loaded over a waiting result");

endmodule

`default_nettype wire

// ----- design/spint_datapath.sv -----
// profile table, run state, interpolation arithmetic and result register
`default_nettype none

module spint_datapath #(
   parameter int POINTS = spint_pkg::POINTS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spint_pkg::cmd_type                  cmd,
   output spint_pkg::status_type               status,
   input  logic                                csr_write,
   input  logic [spint_pkg::INTERVAL_W-1:0]    csr_wdata,
   input  logic [spint_pkg::KIND_W-1:0]        req_kind,
   input  logic [spint_pkg::SLOT_W-1:0]        req_point_index,
   input  logic [spint_pkg::DATA_W-1:0]        req_point_time,
   input  logic [spint_pkg::DATA_W-1:0]        req_point_temperature,
   input  logic [spint_pkg::DATA_W-1:0]        req_elapsed_minutes,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_setpoint_changed,
   output logic [spint_pkg::DATA_W-1:0]        rsp_setpoint,
   output logic [spint_pkg::PHASE_W-1:0]       rsp_phase
);

   localparam int IDX_W  = $clog2(POINTS);
   localparam int WIDE_W = spint_pkg::SLOT_W + IDX_W;
   localparam int DW     = spint_pkg::DATA_W;
   localparam int MEM_W  = 2 * DW;
   localparam int SPAN_W = spint_pkg::SPAN_W;
   localparam int PROD_W = spint_pkg::PROD_W;
   localparam int DIV_W  = spint_pkg::DIV_W;
   localparam int REM_W  = spint_pkg::REM_W;
   localparam int CNT_W  = spint_pkg::CNT_W;

   // latched transaction
   logic [spint_pkg::KIND_W-1:0] kind_ff;
   logic [spint_pkg::SLOT_W-1:0] slot_ff;
   logic [DW-1:0]                ptime_ff, ptemp_ff, elapsed_ff;

   // run state
   logic [spint_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [POINTS-1:0]                valid_ff, valid_in;
   logic                             running_ff, running_in;
   logic [IDX_W-1:0]                 event_index_ff, event_index_in;
   logic [DW-1:0]                    last_ff, last_in;
   logic [DW-1:0]                    setpoint_ff, setpoint_in;
   logic                             changed_ff, changed_in;

   // table read
   logic             rd_valid_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [MEM_W-1:0] ram_data;
   logic [DW-1:0]    rd_time, rd_temp;

   // table write
   logic [WIDE_W-1:0] slot_wide;
   logic [IDX_W-1:0]  wr_addr;
   logic              slot_ok;
   logic              wr_en;

   // interpolation
   logic [DW-1:0]            cur_time_ff, cur_temp_ff, prev_temp_ff;
   logic signed [SPAN_W-1:0] span_ff, dtemp_ff, de_ff;
   logic signed [SPAN_W-1:0] span_in, dtemp_in, de_in;
   logic signed [PROD_W-1:0] product_ff, product_in;
   logic [PROD_W-1:0]        mag;
   logic [DIV_W-1:0]         dividend;
   logic                     neg_ff;
   logic [DIV_W-1:0]         quo_ff, quo_in;
   logic [REM_W-1:0]         divisor_ff, rem_ff, rem_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [REM_W:0]           trial, trial_diff;
   logic                     fits;
   logic [DIV_W:0]           sum_pos;
   logic [DIV_W-1:0]         prev_wide;
   logic [DW-1:0]            interp_value;

   // interval test
   logic [DW-1:0] since_last;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_changed_ff;
   logic [DW-1:0]                  rsp_setpoint_ff;
   logic [spint_pkg::PHASE_W-1:0]  rsp_phase_ff, rsp_phase_in;

   // ---------------- table ----------------
   assign slot_wide = {{IDX_W{1'b0}}, slot_ff};
   assign wr_addr   = slot_wide[IDX_W-1:0];
   assign slot_ok   = slot_wide < WIDE_W'(POINTS);
   assign wr_en     = cmd.do_write && slot_ok;

   assign rd_en   = cmd.rd_cur || cmd.rd_prev;
   assign rd_addr = cmd.rd_prev ? IDX_W'(event_index_ff - 1'b1) : event_index_ff;

   spint_ram #(
      .WIDTH (MEM_W),
      .DEPTH (POINTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({ptime_ff, ptemp_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   // slots never written read as an invalid point at zero degrees
   assign rd_time = rd_valid_ff ? ram_data[MEM_W-1:DW] : '1;
   assign rd_temp = rd_valid_ff ? ram_data[DW-1:0] : '0;

   // ---------------- run state ----------------
   always_comb begin
      interval_in    = csr_write ? csr_wdata : interval_ff;
      valid_in       = valid_ff;
      running_in     = running_ff;
      event_index_in = event_index_ff;
      last_in        = last_ff;
      setpoint_in    = setpoint_ff;
      changed_in     = changed_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (cmd.do_start) begin
         running_in     = 1'b1;
         event_index_in = '0;
         last_in        = '0;
      end
      if (cmd.do_stop) begin
         running_in = 1'b0;
      end
      if (cmd.load_item) begin
         changed_in = 1'b0;
      end
      if (cmd.apply) begin
         setpoint_in    = rd_temp;
         event_index_in = IDX_W'(event_index_ff + 1'b1);
         last_in        = elapsed_ff;
         changed_in     = 1'b1;
      end
      if (cmd.prev_load) begin
         last_in = elapsed_ff;
      end
      if (cmd.finish) begin
         setpoint_in = interp_value;
         changed_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff    <= spint_pkg::INTERVAL_RESET;
         valid_ff       <= '0;
         running_ff     <= 1'b0;
         event_index_ff <= '0;
         last_ff        <= '0;
         setpoint_ff    <= '0;
         changed_ff     <= 1'b0;
      end else begin
         interval_ff    <= interval_in;
         valid_ff       <= valid_in;
         running_ff     <= running_in;
         event_index_ff <= event_index_in;
         last_ff        <= last_in;
         setpoint_ff    <= setpoint_in;
         changed_ff     <= changed_in;
      end
   end

   // ---------------- transaction latch and read tag ----------------
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff    <= req_kind;
         slot_ff    <= req_point_index;
         ptime_ff   <= req_point_time;
         ptemp_ff   <= req_point_temperature;
         elapsed_ff <= req_elapsed_minutes;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // ---------------- interpolation ----------------
   assign span_in  = $signed({1'b0, cur_time_ff}) - $signed({1'b0, rd_time});
   assign dtemp_in = $signed({1'b0, cur_temp_ff}) - $signed({1'b0, rd_temp});
   assign de_in    = $signed({1'b0, elapsed_ff}) - $signed({1'b0, rd_time});

   assign product_in = dtemp_ff * de_ff;

   assign mag      = product_ff[PROD_W-1] ? PROD_W'(-product_ff) : product_ff;
   assign dividend = {mag[PROD_W-2:0], 1'b0}
                   + {{(DIV_W-SPAN_W){1'b0}}, span_ff};

   // restoring division, one quotient bit per cycle
   assign trial      = {rem_ff, quo_ff[DIV_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign fits       = trial >= {1'b0, divisor_ff};
   assign rem_in     = fits ? trial_diff[REM_W-1:0] : trial[REM_W-1:0];
   assign quo_in     = {quo_ff[DIV_W-2:0], fits};
   assign cnt_in     = CNT_W'(cnt_ff - 1'b1);

   // add or subtract the rounded step, clamped to the unsigned range
   assign prev_wide = {{(DIV_W-DW){1'b0}}, prev_temp_ff};
   assign sum_pos   = {1'b0, quo_ff} + {1'b0, prev_wide};
   always_comb begin
      if (!neg_ff) begin
         interp_value = (sum_pos[DIV_W:DW] != '0) ? '1 : sum_pos[DW-1:0];
      end else if (quo_ff > prev_wide) begin
         interp_value = '0;
      end else begin
         interp_value = DW'(prev_temp_ff - quo_ff[DW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.arm) begin
         cur_time_ff <= rd_time;
         cur_temp_ff <= rd_temp;
      end
      if (cmd.prev_load) begin
         prev_temp_ff <= rd_temp;
         span_ff      <= span_in;
         dtemp_ff     <= dtemp_in;
         de_ff        <= de_in;
      end
      if (cmd.mul) begin
         product_ff <= product_in;
      end
      if (cmd.div_init) begin
         neg_ff     <= product_ff[PROD_W-1];
         quo_ff     <= dividend;
         divisor_ff <= {span_ff, 1'b0};
         rem_ff     <= '0;
         cnt_ff     <= CNT_W'(DIV_W - 1);
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   // ---------------- status ----------------
   assign since_last = elapsed_ff - last_ff;

   always_comb begin
      status.kind          = kind_ff;
      status.running       = running_ff;
      status.slot_done     = (event_index_ff >= IDX_W'(POINTS - 1)) ||
                             (rd_time >= spint_pkg::TIME_LIMIT);
      status.reached       = elapsed_ff >= rd_time;
      status.interval_ok   = (elapsed_ff < last_ff) ||
                             (since_last >= {{(DW-spint_pkg::INTERVAL_W){1'b0}}, interval_ff});
      status.index_nonzero = event_index_ff != '0;
      status.span_pos      = !span_in[SPAN_W-1] && (span_in != '0);
      status.div_last      = cnt_ff == '0;
      status.rsp_free      = !rsp_valid_ff || !rsp_stall;
   end

   // ---------------- result register ----------------
   always_comb begin
      if (!running_ff) begin
         rsp_phase_in = spint_pkg::PHASE_IDLE;
      end else if (status.slot_done) begin
         rsp_phase_in = spint_pkg::PHASE_DONE;
      end else begin
         rsp_phase_in = spint_pkg::PHASE_RUN;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_changed_ff  <= changed_ff;
         rsp_setpoint_ff <= setpoint_ff;
         rsp_phase_ff    <= rsp_phase_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_setpoint_changed = rsp_changed_ff;
   assign rsp_setpoint         = rsp_setpoint_ff;
   assign rsp_phase            = rsp_phase_ff;

   // a loaded result is presented on the next cycle
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("result register not loaded");

   // applying a point moves the run to the next slot
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> event_index_ff == IDX_W'($past(event_index_ff) + 1'b1))
      else $error("event index did not advance");

   // the setpoint moves only together with the changed flag
   a_setpoint_flag: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && setpoint_ff != $past(setpoint_ff) |-> changed_ff)
      else $error("setpoint changed without flag");

endmodule

`default_nettype wire

// ----- design/setpoint_profile_interpolator.sv -----
// Ramp/soak setpoint profile generator. Each request transaction is one of:
// write a profile point (slot, time in minutes, temperature), start a run,
// evaluate at a given elapsed minute, or stop. Every request yields exactly
// one response transaction with the current setpoint, a changed flag and the
// run phase (idle, executing, completed). Points with a time of 1000 or more
// are invalid; the table reads as all invalid after reset, tracked by one
// valid flip-flop per slot, so no clearing pass is needed. Requests are
// handled one at a time. Each passes from the execute state to the phase
// check state, where the response is loaded; a running evaluation also checks
// the current point, one that may interpolate checks the previous point, and
// one that interpolates runs the multiplier and the 34-step restoring divider
// that forms the rounded fraction (dTemp * dt) / span with rounding half
// away from zero. The next request is accepted in the cycle after the load;
// a stalled earlier response delays the load. A finished response sits in an
// output register, so the next request is accepted while it waits to be
// taken. The interval register may be written only while no request is in
// flight.
`default_nettype none

module setpoint_profile_interpolator #(
   parameter int POINTS = spint_pkg::POINTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [spint_pkg::KIND_W-1:0]      req_kind,
   input  logic [spint_pkg::SLOT_W-1:0]      req_point_index,
   input  logic [spint_pkg::DATA_W-1:0]      req_point_time,
   input  logic [spint_pkg::DATA_W-1:0]      req_point_temperature,
   input  logic [spint_pkg::DATA_W-1:0]      req_elapsed_minutes,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_setpoint_changed,
   output logic [spint_pkg::DATA_W-1:0]      rsp_setpoint,
   output logic [spint_pkg::PHASE_W-1:0]     rsp_phase,
   // interval register write
   input  logic                              csr_write,
   input  logic [spint_pkg::INTERVAL_W-1:0]  csr_wdata
);

   // commands from the sequencer, flags back from the datapath
   spint_pkg::cmd_type    cmd;
   spint_pkg::status_type status;

   // sequencer: one request transaction at a time
   spint_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table, run state, multiplier, divider and response register
   spint_datapath #(
      .POINTS (POINTS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_write             (csr_write),
      .csr_wdata             (csr_wdata),
      .req_kind              (req_kind),
      .req_point_index       (req_point_index),
      .req_point_time        (req_point_time),
      .req_point_temperature (req_point_temperature),
      .req_elapsed_minutes   (req_elapsed_minutes),
      .rsp_stall             (rsp_stall),
      .rsp_valid             (rsp_valid),
      .rsp_setpoint_changed  (rsp_setpoint_changed),
      .rsp_setpoint          (rsp_setpoint),
      .rsp_phase             (rsp_phase)
   );

endmodule

`default_nettype wire

// ----- verif/tb_setpoint_profile_interpolator.sv -----
// self-checking testbench for the setpoint profile interpolator
`default_nettype none

module tb_setpoint_profile_interpolator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KIND_W     = spint_pkg::KIND_W;
   localparam int SLOT_W     = spint_pkg::SLOT_W;
   localparam int DATA_W     = spint_pkg::DATA_W;
   localparam int PHASE_W    = spint_pkg::PHASE_W;
   localparam int INTERVAL_W = spint_pkg::INTERVAL_W;

   localparam int PROFILE_SLOTS = spint_pkg::POINTS_DEFAULT;
   // cycles with no transaction on either channel before the run is declared hung
   localparam int HANG_LIMIT    = 4000;
   // quiet cycles after the last response, covers the longest interpolation
   localparam int SETTLE_CYCLES = 60;
   // random transactions per interval setting
   localparam int PHASE_REQS    = 150;

   // one request transaction as it goes onto the request channel
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] ptime;
      logic [DATA_W-1:0] ptemp;
      logic [DATA_W-1:0] elapsed;
   } profile_req_type;

   // one response transaction
   typedef struct {
      logic               changed;
      logic [DATA_W-1:0]  setpoint;
      logic [PHASE_W-1:0] phase;
   } setpoint_rsp_type;

   // ------------------------------------------------------------------
   // clock, reset and block ports
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid             = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind              = spint_pkg::KIND_WRITE;
   logic [SLOT_W-1:0]     req_point_index       = '0;
   logic [DATA_W-1:0]     req_point_time        = '0;
   logic [DATA_W-1:0]     req_point_temperature = '0;
   logic [DATA_W-1:0]     req_elapsed_minutes   = '0;
   logic                  rsp_valid;
   logic                  rsp_stall             = 1'b0;
   logic                  rsp_setpoint_changed;
   logic [DATA_W-1:0]     rsp_setpoint;
   logic [PHASE_W-1:0]    rsp_phase;
   logic                  csr_write             = 1'b0;
   logic [INTERVAL_W-1:0] csr_wdata             = '0;

   always #5 clock = ~clock;

   setpoint_profile_interpolator dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_kind              (req_kind),
      .req_point_index       (req_point_index),
      .req_point_time        (req_point_time),
      .req_point_temperature (req_point_temperature),
      .req_elapsed_minutes   (req_elapsed_minutes),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_setpoint_changed  (rsp_setpoint_changed),
      .rsp_setpoint          (rsp_setpoint),
      .rsp_phase             (rsp_phase),
      .csr_write             (csr_write),
      .csr_wdata             (csr_wdata)
   );

   // ------------------------------------------------------------------
   // profile model: table, run state and interval as the block holds them
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] time_tab [PROFILE_SLOTS] = '{default: '1};
   logic [DATA_W-1:0] temp_tab [PROFILE_SLOTS] = '{default: '0};
   int                run_slot    = 0;
   int                last_upd    = 0;
   bit                run_on      = 1'b0;
   logic [DATA_W-1:0] setpoint_q  = '0;
   int                interval_q  = int'(spint_pkg::INTERVAL_RESET);

   // run is over at the last slot or at an invalid point
   function automatic bit profile_done();
      if (run_slot >= PROFILE_SLOTS - 1)
         return 1'b1;
      return time_tab[run_slot] >= spint_pkg::TIME_LIMIT;
   endfunction

   // applies one request to the model and returns the response it must cause
   function automatic setpoint_rsp_type predict_setpoint(profile_req_type r);
      setpoint_rsp_type res;
      longint           tp, tc, span, num, mag, q, v;
      int               e;
      res.changed = 1'b0;
      e = int'(r.elapsed);
      case (r.kind)
         spint_pkg::KIND_WRITE: begin
            time_tab[r.slot] = r.ptime;
            temp_tab[r.slot] = r.ptemp;
         end
         spint_pkg::KIND_START: begin
            // restart keeps the setpoint, clears the update mark
            run_slot = 0;
            last_upd = 0;
            run_on   = 1'b1;
         end
         spint_pkg::KIND_EVAL: begin
            if (run_on && !profile_done()) begin
               if (e >= int'(time_tab[run_slot])) begin
                  // point reached: take its temperature and move on
                  setpoint_q  = temp_tab[run_slot];
                  run_slot    = run_slot + 1;
                  last_upd    = e;
                  res.changed = 1'b1;
               end else if ((e < last_upd || e - last_upd >= interval_q) && run_slot > 0) begin
                  // elapsed going backwards counts as an expired interval
                  tp   = longint'(time_tab[run_slot-1]);
                  tc   = longint'(time_tab[run_slot]);
                  span = tc - tp;
                  if (span > 0) begin
                     num = (longint'(temp_tab[run_slot]) - longint'(temp_tab[run_slot-1]))
                           * (longint'(e) - tp);
                     mag = (num < 0) ? -num : num;
                     // exact division, half away from zero
                     q   = (2 * mag + span) / (2 * span);
                     if (num < 0)
                        q = -q;
                     v = longint'(temp_tab[run_slot-1]) + q;
                     if (v < 0)
                        v = 0;
                     if (v > 65535)
                        v = 65535;
                     setpoint_q  = v[DATA_W-1:0];
                     res.changed = 1'b1;
                  end
                  // a non-positive span still moves the update mark
                  last_upd = e;
               end
            end
         end
         default: run_on = 1'b0;
      endcase
      res.setpoint = setpoint_q;
      if (!run_on)
         res.phase = spint_pkg::PHASE_IDLE;
      else if (profile_done())
         res.phase = spint_pkg::PHASE_DONE;
      else
         res.phase = spint_pkg::PHASE_RUN;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // request side: pending queue, acceptance and driver
   // ------------------------------------------------------------------
   profile_req_type  pending_reqs [$];
   setpoint_rsp_type expected_setpoints [$];
   int               reqs_queued  = 0;
   int               mismatches   = 0;
   bit               req_fired    = 1'b0;
   int               req_gap      = 0;
   bit               req_idle_on  = 1'b1;
   int               stall_left   = 0;
   bit               rsp_idle_on  = 1'b1;

   // a request transaction is accepted here and its response predicted at once
   always @(posedge clock) begin : req_accept
      profile_req_type r;
      req_fired = !reset && req_valid && !req_stall;
      if (req_fired) begin
         r.kind    = req_kind;
         r.slot    = req_point_index;
         r.ptime   = req_point_time;
         r.ptemp   = req_point_temperature;
         r.elapsed = req_elapsed_minutes;
         expected_setpoints.push_back(predict_setpoint(r));
         // now and then switch between idling and back-to-back traffic
         if ($urandom_range(0, 47) == 0)
            req_idle_on = !req_idle_on;
      end
   end

   // inputs move on the falling edge only; one nonblocking write per signal
   always @(negedge clock) begin : req_driver
      profile_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // stalled: the payload holds
      end else if (req_gap != 0) begin
         req_gap   = req_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
         nxt = pending_reqs.pop_front();
         req_valid             <= 1'b1;
         req_kind              <= nxt.kind;
         req_point_index       <= nxt.slot;
         req_point_time        <= nxt.ptime;
         req_point_temperature <= nxt.ptemp;
         req_elapsed_minutes   <= nxt.elapsed;
         // gap that follows this transaction
         req_gap = req_idle_on ? $urandom_range(0, 3) : 0;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // response side: stall driver and checker
   // ------------------------------------------------------------------
   always @(negedge clock) begin : rsp_stall_driver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0)
            stall_left = stall_left - 1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      setpoint_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_setpoints.size() == 0) begin
            mismatches = mismatches + 1;
            $display("%0t: response with nothing pending: changed %0b setpoint %0d phase %0d",
                     $time, rsp_setpoint_changed, rsp_setpoint, rsp_phase);
         end else begin
            exp_rsp = expected_setpoints.pop_front();
            if (rsp_setpoint_changed !== exp_rsp.changed) begin
               mismatches = mismatches + 1;
               $display("%0t: setpoint_changed expected %0b actual %0b",
                        $time, exp_rsp.changed, rsp_setpoint_changed);
            end
            if (rsp_setpoint !== exp_rsp.setpoint) begin
               mismatches = mismatches + 1;
               $display("%0t: setpoint expected %0d actual %0d",
                        $time, exp_rsp.setpoint, rsp_setpoint);
            end
            if (rsp_phase !== exp_rsp.phase) begin
               mismatches = mismatches + 1;
               $display("%0t: phase expected %0d actual %0d",
                        $time, exp_rsp.phase, rsp_phase);
            end
         end
         stall_left = rsp_idle_on ? $urandom_range(0, 3) : 0;
         if ($urandom_range(0, 47) == 0)
            rsp_idle_on = !rsp_idle_on;
      end
   end

   // hang detection: any transaction or register write restarts the count
   int quiet_cycles = 0;
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------
   task automatic push_req(logic [KIND_W-1:0] kind, int slot, int ptime, int ptemp,
                           int elapsed);
      profile_req_type r;
      r.kind    = kind;
      r.slot    = slot[SLOT_W-1:0];
      r.ptime   = ptime[DATA_W-1:0];
      r.ptemp   = ptemp[DATA_W-1:0];
      r.elapsed = elapsed[DATA_W-1:0];
      pending_reqs.push_back(r);
      reqs_queued = reqs_queued + 1;
   endtask

   // start, stop and evaluate carry random don't-care fields so every bit toggles
   task automatic push_ctrl(logic [KIND_W-1:0] kind, int elapsed);
      push_req(kind, $urandom_range(0, 15), $urandom_range(0, 65535),
               $urandom_range(0, 65535), elapsed);
   endtask

   task automatic push_noise();
      push_req(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 15),
               $urandom_range(0, 65535), $urandom_range(0, 65535),
               $urandom_range(0, 65535));
   endtask

   // mostly small temperatures, a quarter over the full range for saturation
   function automatic int rand_temp();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 65535);
      return $urandom_range(0, 400);
   endfunction

   // one well-formed profile (mostly rising times, then an invalid marker)
   // followed by a run of evaluations with occasional disturbances
   task automatic gen_profile_run();
      int npts, t, el, nev;
      npts = ($urandom_range(0, 7) == 0) ? PROFILE_SLOTS : $urandom_range(1, 8);
      t    = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 30);
      for (int s = 0; s < npts; s++) begin
         if (s != 0) begin
            case ($urandom_range(0, 11))
               0:       t = t;                                       // flat span
               1:       t = (t > 20) ? t - $urandom_range(1, 20) : t; // falling time
               default: t = t + $urandom_range(1, 60);
            endcase
         end
         if (t > int'(spint_pkg::TIME_LIMIT) - 1)
            t = int'(spint_pkg::TIME_LIMIT) - 1;
         push_req(spint_pkg::KIND_WRITE, s, t, rand_temp(), $urandom_range(0, 65535));
      end
      if (npts < PROFILE_SLOTS)
         push_req(spint_pkg::KIND_WRITE, npts,
                  $urandom_range(int'(spint_pkg::TIME_LIMIT), 65535), rand_temp(),
                  $urandom_range(0, 65535));
      push_ctrl(spint_pkg::KIND_START, $urandom_range(0, 65535));
      el  = 0;
      nev = $urandom_range(8, 40);
      for (int i = 0; i < nev; i++) begin
         case ($urandom_range(0, 24))
            0: el = $urandom_range(0, 65535);                        // wild jump
            1: el = (el > 30) ? el - $urandom_range(1, 30) : 0;      // going backwards
            2: push_req(spint_pkg::KIND_WRITE, $urandom_range(0, 15),
                        $urandom_range(0, 1100), rand_temp(), $urandom_range(0, 65535));
            3: begin
               push_ctrl(spint_pkg::KIND_START, $urandom_range(0, 65535));
               el = 0;
            end
            4: push_ctrl(spint_pkg::KIND_STOP, $urandom_range(0, 65535));
            5: push_noise();
            default: el = el + $urandom_range(0, 12);
         endcase
         if (el > 65535)
            el = 65535;
         push_req(spint_pkg::KIND_EVAL, $urandom_range(0, 15), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), el);
      end
      if ($urandom_range(0, 1) == 0)
         push_ctrl(spint_pkg::KIND_STOP, $urandom_range(0, 65535));
   endtask

   // wait until every queued transaction has been answered
   task automatic drain_profile();
      do
         @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_setpoints.size() != 0);
   endtask

   // the block must be idle before the interval register changes
   task automatic set_interval(int value);
      drain_profile();
      repeat (50) @(posedge clock);
      @(negedge clock);
      csr_write  <= 1'b1;
      csr_wdata  <= value[INTERVAL_W-1:0];
      interval_q = value;
      @(negedge clock);
      csr_write  <= 1'b0;
   endtask

   initial begin : stimulus
      int target;
      int intervals [6];
      intervals = '{0, 255, 5, 1, 2, 128};

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle and empty-table corners
      push_ctrl(spint_pkg::KIND_EVAL, 5);                 // evaluate while idle
      push_ctrl(spint_pkg::KIND_STOP, 0);                 // stop while idle
      push_ctrl(spint_pkg::KIND_START, 0);                // start on an all-invalid table
      push_ctrl(spint_pkg::KIND_EVAL, 0);                 // evaluate while completed
      // a small ramp/soak profile ending in an invalid point
      push_req(spint_pkg::KIND_WRITE, 0, 0, 100, 0);
      push_req(spint_pkg::KIND_WRITE, 1, 10, 500, 0);
      push_req(spint_pkg::KIND_WRITE, 2, 20, 0, 0);
      push_req(spint_pkg::KIND_WRITE, 3, 30, 65535, 0);
      push_req(spint_pkg::KIND_WRITE, 4, 1000, 77, 0);
      push_ctrl(spint_pkg::KIND_START, 0);
      push_ctrl(spint_pkg::KIND_EVAL, 0);                 // first point applied
      push_ctrl(spint_pkg::KIND_EVAL, 3);                 // rising interpolation
      push_ctrl(spint_pkg::KIND_EVAL, 10);
      push_ctrl(spint_pkg::KIND_EVAL, 15);                // falling interpolation
      push_ctrl(spint_pkg::KIND_EVAL, 2);                 // backwards, below previous time
      push_ctrl(spint_pkg::KIND_EVAL, 20);
      push_ctrl(spint_pkg::KIND_EVAL, 25);                // exact half rounds away from zero
      push_req(spint_pkg::KIND_WRITE, 3, 12, 4000, 0);    // rewrite during run, negative span
      push_ctrl(spint_pkg::KIND_EVAL, 11);                // skipped update
      push_ctrl(spint_pkg::KIND_EVAL, 65535);             // reaches the invalid point
      push_ctrl(spint_pkg::KIND_START, 0);                // restart while running
      push_ctrl(spint_pkg::KIND_STOP, 0);
      push_req(spint_pkg::KIND_WRITE, 15, 65535, 65535, 65535); // last slot, all ones
      push_ctrl(spint_pkg::KIND_EVAL, 65535);

      // random phases, one interval setting each; the reset value runs first
      target = reqs_queued + PHASE_REQS;
      while (reqs_queued < target) begin
         if ($urandom_range(0, 9) == 0)
            push_noise();
         else
            gen_profile_run();
      end
      foreach (intervals[i]) begin
         set_interval((i == 5) ? $urandom_range(1, 255) : intervals[i]);
         target = reqs_queued + PHASE_REQS;
         while (reqs_queued < target) begin
            if ($urandom_range(0, 9) == 0)
               push_noise();
            else
               gen_profile_run();
         end
      end

      drain_profile();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_setpoints.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
design/spint_pkg.sv
design/spint_ram.sv
design/spint_ctrl.sv
design/spint_datapath.sv
design/setpoint_profile_interpolator.sv
verif/tb_setpoint_profile_interpolator.sv
